FILE: rtl/core/hrp_pkg.sv
// Shared types, constants and prefix-tree tables for the request-line parser.
package hrp_pkg;

  localparam int URL_DEPTH_DEF = 2048;
  localparam int NODE_W        = 5;
  localparam int NODE_COUNT    = 32;
  localparam int EDGE_COUNT    = 31;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [2:0] NO_METHOD  = 3'd7;

  typedef enum logic [2:0] {
    PH_METHOD   = 3'd0,
    PH_URL      = 3'd1,
    PH_DONE     = 3'd2,
    PH_BAD      = 3'd3,
    PH_OVERFLOW = 3'd4
  } phase_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  method_id;
    logic [11:0] url_length;
    logic        url_present;
    logic [7:0]  url_byte;
    logic        url_byte_valid;
    logic        still_accepting;
    logic        chunk_end;
  } result_t;

  typedef struct packed {
    logic              hit;
    logic [NODE_W-1:0] node;
  } trie_step_t;

  localparam logic [NODE_W-1:0] EDGE_FROM [EDGE_COUNT] = '{
    5'd0, 5'd1, 5'd2,
    5'd0, 5'd4, 5'd5, 5'd6,
    5'd4, 5'd8,
    5'd0, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14,
    5'd0, 5'd16, 5'd17, 5'd18,
    5'd0, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25,
    5'd0, 5'd27, 5'd28, 5'd29, 5'd30
  };

  localparam logic [7:0] EDGE_CHAR [EDGE_COUNT] = '{
    "G", "E", "T",
    "P", "O", "S", "T",
    "U", "T",
    "D", "E", "L", "E", "T", "E",
    "H", "E", "A", "D",
    "O", "P", "T", "I", "O", "N", "S",
    "T", "R", "A", "C", "E"
  };

  localparam logic [NODE_W-1:0] EDGE_TO [EDGE_COUNT] = '{
    5'd1, 5'd2, 5'd3,
    5'd4, 5'd5, 5'd6, 5'd7,
    5'd8, 5'd9,
    5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15,
    5'd16, 5'd17, 5'd18, 5'd19,
    5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26,
    5'd27, 5'd28, 5'd29, 5'd30, 5'd31
  };

  localparam logic [2:0] NODE_METHOD [NODE_COUNT] = '{
    3'd7, 3'd7, 3'd7, 3'd0, 3'd7, 3'd7, 3'd7, 3'd1,
    3'd7, 3'd2, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd3,
    3'd7, 3'd7, 3'd7, 3'd4, 3'd7, 3'd7, 3'd7, 3'd7,
    3'd7, 3'd7, 3'd5, 3'd7, 3'd7, 3'd7, 3'd7, 3'd6
  };

  // Edge lookup: all edges compared in parallel, at most one matches.
  function automatic trie_step_t trie_next(input logic [NODE_W-1:0] node,
                                           input logic [7:0] ch);
    trie_step_t r;
    r.hit  = 1'b0;
    r.node = '0;
    for (int i = 0; i < EDGE_COUNT; i++) begin
      if (EDGE_FROM[i] == node && EDGE_CHAR[i] == ch) begin
        r.hit  = 1'b1;
        r.node = EDGE_TO[i];
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/hrp_chan_if.sv
// Valid/ready channel interfaces for request bytes and parse results.
interface hrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_last;

  modport source (output valid, output data_byte, output chunk_last, input ready);
  modport sink   (input valid, input data_byte, input chunk_last, output ready);
endinterface

interface hrp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  method_id;
  logic [11:0] url_length;
  logic        url_present;
  logic [7:0]  url_byte;
  logic        url_byte_valid;
  logic        still_accepting;
  logic        chunk_end;

  modport source (output valid, output status, output method_id, output url_length,
                  output url_present, output url_byte, output url_byte_valid,
                  output still_accepting, output chunk_end, input ready);
  modport sink   (input valid, input status, input method_id, input url_length,
                  input url_present, input url_byte, input url_byte_valid,
                  input still_accepting, input chunk_end, output ready);
endinterface

FILE: rtl/core/http_request_line_method_url_parser_top.sv
// HTTP request-line parser: one byte per ready cycle, method trie walk, URL capture.
//
// Takes one request byte per cycle while not stalled and returns one result per byte,
// in order. Each byte takes at most one prefix-tree step for the method or one write
// into the URL buffer RAM, so requests can be accepted back to back. A result is
// registered in the output register or, while that is held, in the skid entry. The
// two-entry stage holds ready high with one result held, low with two or in reset.
// The URL buffer needs no clearing after reset; it is written in order and never
// read by the parse logic.
module http_request_line_method_url_parser_top
  import hrp_pkg::*;
#(
  parameter int URL_DEPTH = URL_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  hrp_in_if.sink    in_req,
  hrp_out_if.source out_res
);

  localparam int CNT_W  = $clog2(URL_DEPTH + 1);
  localparam int ADDR_W = $clog2(URL_DEPTH);

  phase_t            phase_r, phase_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              seen_r, seen_nxt;
  logic [2:0]        method_r, method_nxt;

  logic       acc;
  logic       wr_en;
  logic [7:0] echo;
  trie_step_t step;
  result_t    res;

  logic    out_valid_r, skid_valid_r;
  result_t out_data_r, skid_data_r;
  logic    out_take;

  assign acc          = in_req.valid && in_req.ready;
  assign in_req.ready = rst_n && !skid_valid_r;
  assign step         = trie_next(node_r, in_req.data_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_METHOD;
      node_r   <= '0;
      cnt_r    <= '0;
      seen_r   <= 1'b0;
      method_r <= NO_METHOD;
    end else if (acc) begin
      phase_r  <= phase_nxt;
      node_r   <= node_nxt;
      cnt_r    <= cnt_nxt;
      seen_r   <= seen_nxt;
      method_r <= method_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    node_nxt   = node_r;
    cnt_nxt    = cnt_r;
    seen_nxt   = seen_r;
    method_nxt = method_r;
    wr_en      = 1'b0;
    echo       = '0;
    unique case (phase_r)
      PH_METHOD: begin
        if (in_req.data_byte == SPACE_BYTE) begin
          if (NODE_METHOD[node_r] != NO_METHOD) begin
            method_nxt = NODE_METHOD[node_r];
            phase_nxt  = PH_URL;
          end else begin
            phase_nxt = PH_BAD;
          end
        end else if (step.hit) begin
          node_nxt = step.node;
        end else begin
          phase_nxt = PH_BAD;
        end
      end
      PH_URL: begin
        if (in_req.data_byte == SPACE_BYTE) begin
          seen_nxt  = seen_r || (cnt_r != '0);
          phase_nxt = PH_DONE;
        end else if (cnt_r < CNT_W'(URL_DEPTH)) begin
          wr_en   = acc;
          cnt_nxt = cnt_r + 1'b1;
          echo    = in_req.data_byte;
        end else begin
          phase_nxt = PH_OVERFLOW;
        end
      end
      PH_DONE, PH_BAD, PH_OVERFLOW: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.status          = phase_nxt;
    res.method_id       = method_nxt;
    res.url_length      = 12'(cnt_nxt);
    res.url_present     = seen_nxt;
    res.url_byte        = echo;
    res.url_byte_valid  = (phase_r == PH_URL) && (phase_nxt == PH_URL) && (cnt_nxt != cnt_r);
    res.still_accepting = (phase_nxt == PH_METHOD) || (phase_nxt == PH_URL);
    res.chunk_end       = in_req.chunk_last;
  end

  hrp_ram #(
    .WIDTH (8),
    .DEPTH (URL_DEPTH)
  ) u_url_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data (in_req.data_byte),
    .rd_en   (1'b0),
    .rd_addr (cnt_r[ADDR_W-1:0]),
    .rd_data ()
  );

  // Output register with skid entry.
  assign out_take = !out_valid_r || out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r  <= skid_valid_r || acc;
      skid_valid_r <= 1'b0;
    end else if (acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (acc) begin
      skid_data_r <= res;
    end
  end

  assign out_res.valid           = out_valid_r;
  assign out_res.status          = out_data_r.status;
  assign out_res.method_id       = out_data_r.method_id;
  assign out_res.url_length      = out_data_r.url_length;
  assign out_res.url_present     = out_data_r.url_present;
  assign out_res.url_byte        = out_data_r.url_byte;
  assign out_res.url_byte_valid  = out_data_r.url_byte_valid;
  assign out_res.still_accepting = out_data_r.still_accepting;
  assign out_res.chunk_end       = out_data_r.chunk_end;

  a_ram_wr_in_url: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (phase_r == PH_URL) && acc)
    else $error("URL buffer written outside URL phase");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(URL_DEPTH))
    else $error("URL count beyond buffer depth");

  a_terminal_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE || phase_r == PH_BAD || phase_r == PH_OVERFLOW)
      |=> $stable(phase_r) && $stable(cnt_r))
    else $error("terminal phase left");

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

  a_method_set_in_url: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_URL || phase_r == PH_DONE || phase_r == PH_OVERFLOW)
      |-> method_r != NO_METHOD)
    else $error("URL phase reached without a method");

endmodule

FILE: rtl/core/hrp_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module hrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
